### src/motor_feedback_multiturn_filter_assert.svh
// Assertion macros for the motor feedback multi-turn filter.
// Used by the port checker; needs nothing else.
`ifndef MOTOR_FEEDBACK_MULTITURN_FILTER_ASSERT_SVH
`define MOTOR_FEEDBACK_MULTITURN_FILTER_ASSERT_SVH

// a in this cycle implies b in the same cycle
`define MFMF_ASSERT_NOW(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("mfmf port check failed");

// a in this cycle implies b in the next cycle
`define MFMF_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("mfmf port check failed");

`endif

### src/mfmf_pkg.sv
// Shared constants and types for the motor feedback multi-turn filter.
// No dependencies.
`default_nettype none
package mfmf_pkg;
	localparam int MUL_A_W = 49;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int MOD_U_W = 50;
	localparam int PI_Q16 = 205887;
	localparam int TWO_PI_Q16 = 411775;
	localparam longint unsigned MOD_BIAS = (64'd1 << 48) % 64'd411775;
	localparam logic [47:0] ANGLE_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [17:0] ALPHA_ONE = 18'h10000;

	typedef enum logic [2:0] {
		REG_SPEED_ALPHA    = 3'd0,
		REG_CURRENT_ALPHA  = 3'd1,
		REG_VELOCITY_SCALE = 3'd2,
		REG_POSITION_SCALE = 3'd3,
		REG_ZERO_OFFSET    = 3'd4
	} cfg_reg_t;
endpackage
`default_nettype wire

### src/mfmf_sermul.sv
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
// No dependencies.
`default_nettype none
module mfmf_sermul #(
	parameter int WA = 49,
	parameter int WB = 18
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [WA-1:0]     a,
	input  wire logic signed [WB-1:0]     b,
	output logic                          done,
	output logic signed [WA+WB-1:0]       prod
);
	localparam int PW = WA + WB;
	localparam int CW = $clog2(WB);

	logic signed [PW-1:0] aa_q, acc_q, term;
	logic [WB-1:0] bb_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q, last;

	assign term = bb_q[0] ? aa_q : '0;
	assign last = (cnt_q == CW'(WB - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !start && busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// sign bit of b carries negative weight
	always_ff @(posedge clk) begin
		if (start) begin
			aa_q <= {{WB{a[WA-1]}}, a};
			bb_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= last ? acc_q - term : acc_q + term;
			aa_q <= aa_q <<< 1;
			bb_q <= bb_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

### src/mfmf_sermod.sv
// Bit-serial restoring remainder by a constant modulus, one dividend bit per cycle.
// No dependencies.
`default_nettype none
module mfmf_sermod #(
	parameter int UW = 50,
	parameter int M = 411775
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [UW-1:0]              u,
	output logic                            done,
	output logic [$clog2(M)-1:0]            rem
);
	localparam int RW = $clog2(M) + 1;
	localparam int CW = $clog2(UW);

	logic [RW-1:0] rem_q, t;
	logic [UW-1:0] sh_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q, last;

	assign t = {rem_q[RW-2:0], sh_q[UW-1]};
	assign last = (cnt_q == CW'(UW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !start && busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= u;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q <= sh_q << 1;
			rem_q <= (t >= RW'(M)) ? t - RW'(M) : t;
		end
	end

	assign done = done_q;
	assign rem = rem_q[RW-2:0];
endmodule
`default_nettype wire

### src/motor_feedback_multiturn_filter.sv
// Motor feedback multi-turn filter: one frame in, one result out. A frame is
// taken only while the block is idle; once the result is in the output register the
// next frame can be accepted. Seven products run one after another through a
// single bit-serial multiplier, each with a start step, a shift per multiplier bit
// and a done step, and the wrapped angle then takes a serial remainder with
// hand-off states around it. A finished result waits in the output register
// while the next frame is taken. There is no clearing pass after reset.
// Uses mfmf_pkg, mfmf_sermul and mfmf_sermod.
`default_nettype none
module motor_feedback_multiturn_filter #(
	parameter int COUNTS_PER_TURN_BITS = 13,
	parameter int TURN_BITS = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [2:0]                      cfg_index,
	input  wire logic [31:0]                     cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [COUNTS_PER_TURN_BITS-1:0] angle_raw,
	input  wire logic signed [15:0]              speed_raw,
	input  wire logic signed [15:0]              current_raw,
	input  wire logic [7:0]                      temperature_raw,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [31:0]                   speed_filtered,
	output logic signed [31:0]                   current_filtered,
	output logic signed [TURN_BITS-1:0]          turn_total,
	output logic signed [47:0]                   angle_total,
	output logic signed [18:0]                   angle_wrapped,
	output logic [7:0]                           temperature
);
	import mfmf_pkg::*;

	localparam int C = COUNTS_PER_TURN_BITS;
	localparam int T = TURN_BITS;
	localparam int MAG_W = T + C;
	localparam int CNT_W = T + C + 1;
	localparam int PW = MUL_P_W;
	localparam int QW = PW + 16;
	localparam int REM_W = $clog2(TWO_PI_Q16);
	localparam logic [C-1:0] HALF_TURN = {1'b1, {(C-1){1'b0}}};
	localparam logic [T-1:0] TURN_MIN = {1'b1, {(T-1){1'b0}}};
	localparam logic [T-1:0] TURN_MAX = {1'b0, {(T-1){1'b1}}};

	typedef enum logic [3:0] {
		ST_IDLE, ST_SPD_X, ST_SPD_Y, ST_SPD_AX, ST_CUR_Y, ST_CUR_AX,
		ST_ANG_LO, ST_ANG_HI, ST_MOD_GO, ST_MOD, ST_OUT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] hi, lo;
		hi = $signed({{(PW-32){1'b0}}, 32'h7FFF_FFFF});
		lo = $signed({{(PW-32){1'b1}}, 32'h8000_0000});
		if (v > hi) return 32'sh7FFF_FFFF;
		if (v < lo) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	state_t state_q;
	logic [15:0] speed_alpha_q, current_alpha_q;
	logic signed [31:0] velocity_scale_q;
	logic [31:0] position_scale_q;
	logic [12:0] zero_offset_q;

	logic [C-1:0] prev_count_q;
	logic [T-1:0] turns_q;
	logic signed [31:0] speed_acc_q, current_acc_q;

	logic signed [15:0] current_q;
	logic [7:0] temp_q;
	logic [MAG_W-1:0] mag_q;
	logic neg_q;
	logic signed [47:0] x_q, angle_q;
	logic signed [PW-1:0] sum_q;
	logic signed [18:0] wrapped_q;

	logic mul_start_q, mod_start_q;
	logic signed [MUL_A_W-1:0] mul_a_q;
	logic signed [MUL_B_W-1:0] mul_b_q;
	logic mul_done, mod_done;
	logic signed [PW-1:0] prod;
	logic [REM_W-1:0] rem;

	// frame decode: wrap detection and count magnitude
	logic [C:0] diff;
	logic wrap_dn, wrap_up;
	logic [T-1:0] turns_n;
	logic [28:0] zo_wide;
	logic signed [CNT_W-1:0] counts;
	logic [CNT_W-1:0] counts_abs;

	assign diff = {1'b0, angle_raw} - {1'b0, prev_count_q};
	assign wrap_dn = !diff[C] && (diff[C-1:0] > HALF_TURN);
	assign wrap_up = diff[C] && (diff[C-1:0] < HALF_TURN);

	always_comb begin
		turns_n = turns_q;
		if (wrap_dn && turns_q != TURN_MIN) turns_n = turns_q - T'(1);
		else if (wrap_up && turns_q != TURN_MAX) turns_n = turns_q + T'(1);
	end

	assign zo_wide = {16'b0, zero_offset_q};
	assign counts = $signed({turns_n[T-1], turns_n, {C{1'b0}}})
		+ $signed({{(T+1){1'b0}}, angle_raw})
		- $signed({{(T+1){1'b0}}, zo_wide[C-1:0]});
	assign counts_abs = counts[CNT_W-1] ? -counts : counts;

	// filter and angle post-processing
	logic signed [PW-1:0] spd_sum, cur_sum;
	logic [QW-1:0] qf;
	logic [PW-1:0] q;
	logic [47:0] qs;
	logic [MOD_U_W-1:0] mod_u;
	logic signed [REM_W+1:0] r1, r2;

	assign spd_sum = (sum_q + prod) >>> 16;
	assign cur_sum = (sum_q + (prod <<< 16)) >>> 16;
	assign qf = {16'b0, sum_q} + {prod, 16'b0};
	assign q = qf[QW-1:16];
	assign qs = (q > {{(PW-48){1'b0}}, ANGLE_MAX})
		? (neg_q ? 48'h8000_0000_0000 : ANGLE_MAX) : q[47:0];
	assign mod_u = {{(MOD_U_W-48){angle_q[47]}}, angle_q}
		+ MOD_U_W'(PI_Q16) + (MOD_U_W'(1) << 48);

	always_comb begin
		r1 = $signed({2'b0, rem}) - $signed((REM_W+2)'(MOD_BIAS));
		if (r1 < 0) r1 = r1 + $signed((REM_W+2)'(TWO_PI_Q16));
		r2 = r1 - $signed((REM_W+2)'(PI_Q16));
	end

	mfmf_sermul #(.WA(MUL_A_W), .WB(MUL_B_W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start_q),
		.a(mul_a_q), .b(mul_b_q), .done(mul_done), .prod(prod)
	);

	mfmf_sermod #(.UW(MOD_U_W), .M(TWO_PI_Q16)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start_q),
		.u(mod_u), .done(mod_done), .rem(rem)
	);

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			speed_alpha_q <= 16'd6554;
			current_alpha_q <= 16'd6554;
			velocity_scale_q <= 32'sd6861;
			position_scale_q <= 32'd3294199;
			zero_offset_q <= '0;
			prev_count_q <= '0;
			turns_q <= '0;
			speed_acc_q <= '0;
			current_acc_q <= '0;
			current_q <= '0;
			temp_q <= '0;
			mag_q <= '0;
			neg_q <= 1'b0;
			x_q <= '0;
			angle_q <= '0;
			sum_q <= '0;
			wrapped_q <= '0;
			mul_start_q <= 1'b0;
			mod_start_q <= 1'b0;
			mul_a_q <= '0;
			mul_b_q <= '0;
			out_valid <= 1'b0;
			speed_filtered <= '0;
			current_filtered <= '0;
			turn_total <= '0;
			angle_total <= '0;
			angle_wrapped <= '0;
			temperature <= '0;
		end else begin
			if (out_valid && out_ready && state_q != ST_OUT) out_valid <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_SPEED_ALPHA: speed_alpha_q <= cfg_data[15:0];
					REG_CURRENT_ALPHA: current_alpha_q <= cfg_data[15:0];
					REG_VELOCITY_SCALE: velocity_scale_q <= cfg_data;
					REG_POSITION_SCALE: position_scale_q <= cfg_data;
					REG_ZERO_OFFSET: zero_offset_q <= cfg_data[12:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					mul_start_q <= in_valid;
					if (in_valid) begin
						prev_count_q <= angle_raw;
						turns_q <= turns_n;
						mag_q <= counts_abs[MAG_W-1:0];
						neg_q <= counts[CNT_W-1];
						current_q <= current_raw;
						temp_q <= temperature_raw;
						mul_a_q <= {{(MUL_A_W-32){velocity_scale_q[31]}}, velocity_scale_q};
						mul_b_q <= {{(MUL_B_W-16){speed_raw[15]}}, speed_raw};
						state_q <= ST_SPD_X;
					end
				end
				ST_SPD_X: begin
					mul_start_q <= mul_done;
					if (mul_done) begin
						x_q <= prod[47:0];
						mul_a_q <= {{(MUL_A_W-32){speed_acc_q[31]}}, speed_acc_q};
						mul_b_q <= ALPHA_ONE - {2'b0, speed_alpha_q};
						state_q <= ST_SPD_Y;
					end
				end
				ST_SPD_Y: begin
					mul_start_q <= mul_done;
					if (mul_done) begin
						sum_q <= prod + PW'(32768);
						mul_a_q <= {{(MUL_A_W-48){x_q[47]}}, x_q};
						mul_b_q <= {2'b0, speed_alpha_q};
						state_q <= ST_SPD_AX;
					end
				end
				ST_SPD_AX: begin
					mul_start_q <= mul_done;
					if (mul_done) begin
						speed_acc_q <= sat32(spd_sum);
						mul_a_q <= {{(MUL_A_W-32){current_acc_q[31]}}, current_acc_q};
						mul_b_q <= ALPHA_ONE - {2'b0, current_alpha_q};
						state_q <= ST_CUR_Y;
					end
				end
				ST_CUR_Y: begin
					mul_start_q <= mul_done;
					if (mul_done) begin
						sum_q <= prod + PW'(32768);
						mul_a_q <= {{(MUL_A_W-16){current_q[15]}}, current_q};
						mul_b_q <= {2'b0, current_alpha_q};
						state_q <= ST_CUR_AX;
					end
				end
				ST_CUR_AX: begin
					mul_start_q <= mul_done;
					if (mul_done) begin
						current_acc_q <= sat32(cur_sum);
						mul_a_q <= {{(MUL_A_W-MAG_W){1'b0}}, mag_q};
						mul_b_q <= {2'b0, position_scale_q[15:0]};
						state_q <= ST_ANG_LO;
					end
				end
				ST_ANG_LO: begin
					mul_start_q <= mul_done;
					if (mul_done) begin
						sum_q <= prod + PW'(32768);
						mul_a_q <= {{(MUL_A_W-MAG_W){1'b0}}, mag_q};
						mul_b_q <= {2'b0, position_scale_q[31:16]};
						state_q <= ST_ANG_HI;
					end
				end
				ST_ANG_HI: begin
					mul_start_q <= 1'b0;
					if (mul_done) begin
						angle_q <= neg_q ? -$signed(qs) : $signed(qs);
						state_q <= ST_MOD_GO;
					end
				end
				ST_MOD_GO: begin
					mod_start_q <= 1'b1;
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					mod_start_q <= 1'b0;
					if (mod_done) begin
						wrapped_q <= r2[18:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						speed_filtered <= speed_acc_q;
						current_filtered <= current_acc_q;
						turn_total <= turns_q;
						angle_total <= angle_q;
						angle_wrapped <= wrapped_q;
						temperature <= temp_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					mul_start_q <= 1'b0;
					mod_start_q <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

### src/mfmf_checker.sv
// Port-level checks for the motor feedback multi-turn filter, bound to the top.
// Uses motor_feedback_multiturn_filter_assert.svh.
`default_nettype none
module mfmf_checker #(
	parameter int COUNTS_PER_TURN_BITS = 13,
	parameter int TURN_BITS = 24
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            cfg_we,
	input wire logic [2:0]                      cfg_index,
	input wire logic [31:0]                     cfg_data,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic [COUNTS_PER_TURN_BITS-1:0] angle_raw,
	input wire logic signed [15:0]              speed_raw,
	input wire logic signed [15:0]              current_raw,
	input wire logic [7:0]                      temperature_raw,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic signed [31:0]              speed_filtered,
	input wire logic signed [31:0]              current_filtered,
	input wire logic signed [TURN_BITS-1:0]     turn_total,
	input wire logic signed [47:0]              angle_total,
	input wire logic signed [18:0]              angle_wrapped,
	input wire logic [7:0]                      temperature
);
`include "motor_feedback_multiturn_filter_assert.svh"

	// a stalled result holds
	`MFMF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(angle_total) && $stable(speed_filtered))
	// one transaction at a time
	`MFMF_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	// wrapped angle within [-pi, pi]
	`MFMF_ASSERT_NOW(a_wrap_range, clk, arst_n, out_valid, angle_wrapped <= 19'sd205887 && angle_wrapped >= -19'sd205887)
endmodule

bind motor_feedback_multiturn_filter mfmf_checker #(
	.COUNTS_PER_TURN_BITS(COUNTS_PER_TURN_BITS),
	.TURN_BITS(TURN_BITS)
) u_mfmf_checker (.*);
`default_nettype wire
